>>> src/rgb_hsv_converter_defines.svh
// Assertion macros used by the top-level converter module.
`ifndef RGB_HSV_CONVERTER_DEFINES_SVH
`define RGB_HSV_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rhc: same-cycle check failed");

`define RHC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rhc: next-cycle check failed");

`else

`define RHC_ASSERT_IMP(label, ante, cons)

`define RHC_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> src/rhc_pkg.sv
// Types and constants shared by the RGB/HSV converter modules.
package rhc_pkg;

    localparam logic [7:0] SECTOR_WIDTH = 8'd43;
    localparam logic [7:0] FULL_SCALE   = 8'hFF;
    localparam logic [7:0] GREEN_BASE   = 8'd85;
    localparam logic [7:0] BLUE_BASE    = 8'd171;
    localparam logic [7:0] REM_SCALE    = 8'd6;

    // Two quotient bits are resolved in each divider stage.
    localparam int DIV_STEPS = 4;
    // Register stages from input beat to output register.
    localparam int LATENCY   = 7;

    typedef enum logic {
        DIR_TO_HSV = 1'b0,
        DIR_TO_RGB = 1'b1
    } t_dir;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] res_a;
        logic [7:0] res_b;
        logic [7:0] res_c;
        logic [7:0] alpha_out;
    } t_pix_out;

    // One division in flight: partial remainder, divisor and quotient so far.
    typedef struct packed {
        logic [15:0] num;
        logic [7:0]  den;
        logic [7:0]  quo;
    } t_div;

endpackage

>>> src/rhc_div_step.sv
// One registered stage of the restoring divider, two quotient bits per stage.
module rhc_div_step #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  rhc_pkg::t_div i_div,
    output rhc_pkg::t_div o_div
);
    import rhc_pkg::*;

    localparam int SH_HI = 2 * STEP + 1;
    localparam int SH_LO = 2 * STEP;

    logic [15:0] d_hi;
    logic [15:0] d_lo;
    logic        ge_hi;
    logic        ge_lo;
    logic [15:0] rem_hi;
    t_div        n_div;
    t_div        r_div;

    // The caller guarantees num < den * 256, so no quotient bit is lost above the top step.
    always_comb begin
        d_hi   = 16'(i_div.den) << SH_HI;
        d_lo   = 16'(i_div.den) << SH_LO;
        ge_hi  = (i_div.num >= d_hi);
        rem_hi = ge_hi ? (i_div.num - d_hi) : i_div.num;
        ge_lo  = (rem_hi >= d_lo);
        n_div  = i_div;
        n_div.num = ge_lo ? (rem_hi - d_lo) : rem_hi;
        n_div.quo[SH_HI] = ge_hi;
        n_div.quo[SH_LO] = ge_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

>>> src/rhc_hsv_path.sv
// RGB to HSV datapath: extrema, numerators, pipelined divisions, hue assembly.
module rhc_hsv_path (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_hue,
    output logic [7:0] o_sat,
    output logic [7:0] o_val
);
    import rhc_pkg::*;

    typedef struct packed {
        logic       zero_max;
        logic       zero_delta;
        logic       neg;
        logic [7:0] base;
        logic [7:0] value;
    } t_hsv_side;

    // Stage 1
    logic [7:0] n_mx, n_mn, n_delta, n_base, n_abs;
    logic [7:0] op_x, op_y;
    logic       n_neg;
    logic [7:0] r1_mx, r1_delta, r1_base, r1_abs;
    logic       r1_neg;

    // Stage 2
    t_div      n_sdiv, n_hdiv;
    t_div      r2_sdiv, r2_hdiv;
    t_hsv_side n_side;
    t_hsv_side r2_side;

    // Divider stages
    t_div      sdiv [DIV_STEPS+1];
    t_div      hdiv [DIV_STEPS+1];
    t_hsv_side r_side [DIV_STEPS];

    // Final stage
    t_hsv_side   side_last;
    logic [7:0]  hue_off;
    logic [7:0]  r_hue, r_sat, r_val;

    always_comb begin
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx)  n_mx = i_blue;
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn)  n_mn = i_blue;
        n_delta = n_mx - n_mn;
        // Ties for the maximum go to red first, then green.
        if (n_mx == i_red) begin
            op_x   = i_green;
            op_y   = i_blue;
            n_base = 8'd0;
        end else if (n_mx == i_green) begin
            op_x   = i_blue;
            op_y   = i_red;
            n_base = GREEN_BASE;
        end else begin
            op_x   = i_red;
            op_y   = i_green;
            n_base = BLUE_BASE;
        end
        n_neg = (op_x < op_y);
        n_abs = n_neg ? (op_y - op_x) : (op_x - op_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mx    <= n_mx;
            r1_delta <= n_delta;
            r1_base  <= n_base;
            r1_abs   <= n_abs;
            r1_neg   <= n_neg;
        end
    end

    always_comb begin
        n_sdiv.num = {r1_delta, 8'd0} - {8'd0, r1_delta};
        n_sdiv.den = r1_mx;
        n_sdiv.quo = 8'd0;
        n_hdiv.num = 16'(r1_abs) * 16'(SECTOR_WIDTH);
        n_hdiv.den = r1_delta;
        n_hdiv.quo = 8'd0;
        n_side.zero_max   = (r1_mx == 8'd0);
        n_side.zero_delta = (r1_delta == 8'd0);
        n_side.neg        = r1_neg;
        n_side.base       = r1_base;
        n_side.value      = r1_mx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sdiv <= n_sdiv;
            r2_hdiv <= n_hdiv;
            r2_side <= n_side;
        end
    end

    assign sdiv[0] = r2_sdiv;
    assign hdiv[0] = r2_hdiv;

    // Most significant quotient bits are resolved first.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        rhc_div_step #(
            .STEP (DIV_STEPS - 1 - k)
        ) u_sat_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_div (sdiv[k]),
            .o_div (sdiv[k+1])
        );
        rhc_div_step #(
            .STEP (DIV_STEPS - 1 - k)
        ) u_hue_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_div (hdiv[k]),
            .o_div (hdiv[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= r2_side;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign side_last = r_side[DIV_STEPS-1];

    // Division was done on magnitudes, so negating the quotient truncates toward zero.
    assign hue_off = side_last.neg ? (8'd0 - hdiv[DIV_STEPS].quo) : hdiv[DIV_STEPS].quo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= side_last.value;
            if (side_last.zero_max) begin
                r_hue <= 8'd0;
                r_sat <= 8'd0;
            end else if (side_last.zero_delta) begin
                r_hue <= 8'd0;
                r_sat <= 8'd0;
            end else begin
                r_hue <= side_last.base + hue_off;
                r_sat <= sdiv[DIV_STEPS].quo;
            end
        end
    end

    assign o_hue = r_hue;
    assign o_sat = r_sat;
    assign o_val = r_val;

endmodule

>>> src/rhc_rgb_path.sv
// HSV to RGB datapath: sector split, p/q/t products, channel selection, delay.
module rhc_rgb_path (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_sat,
    input  logic [7:0] i_val,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);
    import rhc_pkg::*;

    localparam int PAD = LATENCY - 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Stage 1
    t_sector    n_sec;
    logic [7:0] n_sbase, n_rem;
    t_sector    r1_sec;
    logic [7:0] r1_rem, r1_sat, r1_val;

    // Stage 2
    logic [15:0] sr_prod, st_prod, p_prod;
    t_sector     r2_sec;
    logic [7:0]  r2_sr, r2_st, r2_p, r2_val;
    logic        r2_gray;

    // Stage 3
    logic [15:0] q_prod, t_prod;
    t_sector     r3_sec;
    logic [7:0]  r3_q, r3_t, r3_p, r3_val;
    logic        r3_gray;

    // Stage 4 and alignment delay
    t_rgb n_rgb;
    t_rgb r_rgb [PAD+1];

    always_comb begin
        if (i_hue < SECTOR_WIDTH) begin
            n_sec   = SEC_0;
            n_sbase = 8'd0;
        end else if (i_hue < 8'(2 * SECTOR_WIDTH)) begin
            n_sec   = SEC_1;
            n_sbase = SECTOR_WIDTH;
        end else if (i_hue < 8'(3 * SECTOR_WIDTH)) begin
            n_sec   = SEC_2;
            n_sbase = 8'(2 * SECTOR_WIDTH);
        end else if (i_hue < 8'(4 * SECTOR_WIDTH)) begin
            n_sec   = SEC_3;
            n_sbase = 8'(3 * SECTOR_WIDTH);
        end else if (i_hue < 8'(5 * SECTOR_WIDTH)) begin
            n_sec   = SEC_4;
            n_sbase = 8'(4 * SECTOR_WIDTH);
        end else begin
            n_sec   = SEC_5;
            n_sbase = 8'(5 * SECTOR_WIDTH);
        end
        // The offset within a sector is below 43, so the scaled value fits in eight bits.
        n_rem = 8'((i_hue - n_sbase) * REM_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sec <= n_sec;
            r1_rem <= n_rem;
            r1_sat <= i_sat;
            r1_val <= i_val;
        end
    end

    assign sr_prod = 16'(r1_sat) * 16'(r1_rem);
    assign st_prod = 16'(r1_sat) * 16'(FULL_SCALE - r1_rem);
    assign p_prod  = 16'(r1_val) * 16'(FULL_SCALE - r1_sat);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sec  <= r1_sec;
            r2_sr   <= sr_prod[15:8];
            r2_st   <= st_prod[15:8];
            r2_p    <= p_prod[15:8];
            r2_val  <= r1_val;
            r2_gray <= (r1_sat == 8'd0);
        end
    end

    assign q_prod = 16'(r2_val) * 16'(FULL_SCALE - r2_sr);
    assign t_prod = 16'(r2_val) * 16'(FULL_SCALE - r2_st);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sec  <= r2_sec;
            r3_q    <= q_prod[15:8];
            r3_t    <= t_prod[15:8];
            r3_p    <= r2_p;
            r3_val  <= r2_val;
            r3_gray <= r2_gray;
        end
    end

    always_comb begin
        if (r3_gray) begin
            n_rgb = '{red: r3_val, green: r3_val, blue: r3_val};
        end else begin
            case (r3_sec)
                SEC_0: n_rgb = '{red: r3_val, green: r3_t,   blue: r3_p};
                SEC_1: n_rgb = '{red: r3_q,   green: r3_val, blue: r3_p};
                SEC_2: n_rgb = '{red: r3_p,   green: r3_val, blue: r3_t};
                SEC_3: n_rgb = '{red: r3_p,   green: r3_q,   blue: r3_val};
                SEC_4: n_rgb = '{red: r3_t,   green: r3_p,   blue: r3_val};
                default: n_rgb = '{red: r3_val, green: r3_p, blue: r3_q};
            endcase
        end
    end

    // The tail stages line this path up with the longer HSV path.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb[0] <= n_rgb;
            for (int k = 1; k <= PAD; k++) begin
                r_rgb[k] <= r_rgb[k-1];
            end
        end
    end

    assign o_red   = r_rgb[PAD].red;
    assign o_green = r_rgb[PAD].green;
    assign o_blue  = r_rgb[PAD].blue;

endmodule

>>> src/rgb_hsv_converter.sv
// Latency runs from an accepted input beat to the output register.
// Throughput: one pixel per clock unless stalled; the pipeline holds up to seven beats.
// Latency is set by the four-stage pipelined dividers for saturation and hue.
// A stall at the output freezes every stage and is passed back to the input.
// Synchronous active-low reset empties the pipeline and sets direction to RGB to HSV.
`include "rgb_hsv_converter_defines.svh"

module rgb_hsv_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rhc_pkg::t_pix_in  i_in_pix,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rhc_pkg::t_pix_out o_out_pix
);
    import rhc_pkg::*;

    localparam int LAST = LATENCY - 1;

    t_dir             r_dir;
    logic [LAST:0]    r_vld;
    t_dir             r_dir_pipe [LATENCY];
    logic [7:0]       r_alpha    [LATENCY];
    logic             en;
    logic             in_beat;
    logic [7:0]       hsv_h, hsv_s, hsv_v;
    logic [7:0]       rgb_r, rgb_g, rgb_b;

    // The whole pipeline advances unless a finished beat is held at the output.
    assign en         = !(r_vld[LAST] && i_out_stall);
    assign o_in_stall = !en;
    assign in_beat    = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_TO_HSV;
        end else if (i_cfg_we) begin
            r_dir <= t_dir'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir_pipe[0] <= r_dir;
            r_alpha[0]    <= i_in_pix.alpha_in;
            for (int k = 1; k < LATENCY; k++) begin
                r_dir_pipe[k] <= r_dir_pipe[k-1];
                r_alpha[k]    <= r_alpha[k-1];
            end
        end
    end

    rhc_hsv_path u_hsv (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_in_pix.chan_a),
        .i_green (i_in_pix.chan_b),
        .i_blue  (i_in_pix.chan_c),
        .o_hue   (hsv_h),
        .o_sat   (hsv_s),
        .o_val   (hsv_v)
    );

    rhc_rgb_path u_rgb (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_hue   (i_in_pix.chan_a),
        .i_sat   (i_in_pix.chan_b),
        .i_val   (i_in_pix.chan_c),
        .o_red   (rgb_r),
        .o_green (rgb_g),
        .o_blue  (rgb_b)
    );

    assign o_out_valid = r_vld[LAST];

    always_comb begin
        o_out_pix.alpha_out = r_alpha[LAST];
        if (r_dir_pipe[LAST] == DIR_TO_RGB) begin
            o_out_pix.res_a = rgb_r;
            o_out_pix.res_b = rgb_g;
            o_out_pix.res_c = rgb_b;
        end else begin
            o_out_pix.res_a = hsv_h;
            o_out_pix.res_b = hsv_s;
            o_out_pix.res_c = hsv_v;
        end
    end

    `RHC_ASSERT_IMP(a_stall_backpressure, r_vld[LAST] && i_out_stall, o_in_stall)
    `RHC_ASSERT_NXT(a_beat_enters, in_beat, r_vld[0])
    `RHC_ASSERT_NXT(a_valid_shifts, !o_in_stall, r_vld[LAST:1] == $past(r_vld[LAST-1:0]))
    `RHC_ASSERT_NXT(a_stall_holds, o_in_stall, r_vld == $past(r_vld))

endmodule
